// ===== rtl/gww_pkg.sv =====
// Shared types, constants and helper functions for the greedy word wrap block.
// No dependencies; imported by every gww_* module and by greedy_word_wrap.
`default_nettype none

package gww_pkg;

	// Sizing
	localparam int GLYPH_ENTRIES  = 256;
	localparam int GLYPH_IDX_BITS = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
	localparam int POS_BITS       = 16;
	localparam int FIFO_DEPTH     = 4;
	localparam int FIFO_IDX_BITS  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);
	localparam int PADDR_BITS     = 3;

	// Command codes
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_TEXT = 2'd1;
	localparam logic [1:0] CMD_NEW  = 2'd2;

	// Register indexes (taken from paddr[2])
	localparam logic REG_LINE_HEIGHT = 1'b0;
	localparam logic REG_BOX_WIDTH   = 1'b1;

	// Reset values of the registers
	localparam logic [7:0]  LINE_HEIGHT_RST = 8'd16;
	localparam logic [15:0] BOX_WIDTH_RST   = 16'd640;

	// Character codes
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] char_code;
		logic [7:0] glyph_advance;
		logic       glyph_present;
	} in_item_t;

	typedef struct packed {
		logic [15:0] out_pos;
		logic [7:0]  out_char;
		logic [15:0] text_height;
		logic        last;
	} out_item_t;

	// One glyph table entry
	typedef struct packed {
		logic       present;
		logic [7:0] advance;
	} glyph_t;

	// Results handed from the wrap stage to the output queue
	typedef struct packed {
		logic [1:0] count;
		out_item_t  res0;
		out_item_t  res1;
	} push_t;

	function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[16] ? 16'hFFFF : sum[15:0];
	endfunction

	function automatic logic [POS_BITS-1:0] pos_inc(input logic [POS_BITS-1:0] p);
		return (p == '1) ? p : p + POS_BITS'(1);
	endfunction

	function automatic logic in_table(input logic [7:0] code);
		return (32'(code) < GLYPH_ENTRIES);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/gww_glyph_mem.sv =====
// Glyph table: synchronous memory with registered read and per-entry valid bits.
// Depends on gww_pkg.
`default_nettype none

module gww_glyph_mem (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          rd_en,
	input  wire logic                          wr_en,
	input  wire logic [gww_pkg::GLYPH_IDX_BITS-1:0] addr,
	input  wire gww_pkg::glyph_t               wr_data,
	output      gww_pkg::glyph_t               rd_data
);
	import gww_pkg::*;

	glyph_t                   mem_q [GLYPH_ENTRIES];
	logic [GLYPH_ENTRIES-1:0] written_q;
	glyph_t                   rd_raw_q;
	logic                     rd_written_q;

	// Storage array and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem_q[addr];
		end
	end

	// Entries never written read as absent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[addr];
			end
		end
	end

	assign rd_data.present = rd_written_q & rd_raw_q.present;
	assign rd_data.advance = rd_raw_q.advance;

endmodule

`default_nettype wire

// ===== rtl/gww_wrap_core.sv =====
// Wrap stage: holds the line state, combines it with the glyph read and pushes results.
// Depends on gww_pkg; fed by gww_glyph_mem, drains into gww_out_fifo.
`default_nettype none

module gww_wrap_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_accept,
	input  wire gww_pkg::in_item_t item,
	input  wire gww_pkg::glyph_t   glyph_s1,
	input  wire logic              fifo_room,
	input  wire logic [7:0]        line_height,
	input  wire logic [15:0]       box_width,
	output      logic              item_ready,
	output      gww_pkg::push_t    push
);
	import gww_pkg::*;

	// Stage 1 item
	logic                valid_s1;
	logic [1:0]          cmd_s1;
	logic [7:0]          char_s1;

	// Line state
	logic [POS_BITS-1:0] wpos_q;
	logic [15:0]         lwidth_q;
	logic [15:0]         was_q;
	logic [POS_BITS-1:0] spos_q;
	logic                sseen_q;
	logic [15:0]         height_q;

	logic [POS_BITS-1:0] wpos_d;
	logic [15:0]         lwidth_d;
	logic [15:0]         was_d;
	logic [POS_BITS-1:0] spos_d;
	logic                sseen_d;
	logic [15:0]         height_d;

	logic                go;
	logic                is_break;
	logic [15:0]         lw1;
	logic [15:0]         was1;
	logic [POS_BITS-1:0] pos1;
	logic [15:0]         h_inc;

	// Stage advances whenever the queue can absorb two results
	assign go         = valid_s1 && fifo_room;
	assign item_ready = !valid_s1 || fifo_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			cmd_s1  <= item.command;
			char_s1 <= item.char_code;
		end
	end

	// Next line state and results
	always_comb begin
		wpos_d   = wpos_q;
		lwidth_d = lwidth_q;
		was_d    = was_q;
		spos_d   = spos_q;
		sseen_d  = sseen_q;
		height_d = height_q;
		push     = '0;
		is_break = (char_s1 == CH_SPACE) || (char_s1 == CH_TAB);
		lw1      = sat_add16(lwidth_q, {8'd0, glyph_s1.advance});
		was1     = sat_add16(was_q, {8'd0, glyph_s1.advance});
		pos1     = pos_inc(wpos_q);
		h_inc    = sat_add16(height_q, {8'd0, line_height});
		if (go) begin
			priority if (cmd_s1 == CMD_NEW) begin
				wpos_d   = '0;
				lwidth_d = '0;
				was_d    = '0;
				spos_d   = '0;
				sseen_d  = 1'b0;
				height_d = {8'd0, line_height};
			end else if (cmd_s1 == CMD_TEXT && char_s1 == CH_NEWLINE) begin
				height_d   = h_inc;
				lwidth_d   = '0;
				was_d      = '0;
				sseen_d    = 1'b0;
				wpos_d     = pos1;
				push.count = 2'd1;
				push.res0  = '{out_pos: 16'(wpos_q), out_char: CH_NEWLINE,
					text_height: h_inc, last: 1'b1};
			end else if (cmd_s1 == CMD_TEXT && in_table(char_s1) && glyph_s1.present) begin
				// Space or tab becomes the break point
				if (is_break) begin
					spos_d  = wpos_q;
					sseen_d = 1'b1;
					was1    = '0;
				end
				wpos_d   = pos1;
				lwidth_d = lw1;
				was_d    = was1;
				if (lw1 > box_width) begin
					// Line too wide: newline at break point, else appended
					height_d   = h_inc;
					was_d      = '0;
					sseen_d    = 1'b0;
					push.count = 2'd2;
					push.res0  = '{out_pos: 16'(wpos_q), out_char: char_s1,
						text_height: h_inc, last: 1'b0};
					if (is_break || sseen_q) begin
						lwidth_d  = was1;
						push.res1 = '{out_pos: 16'(is_break ? wpos_q : spos_q),
							out_char: CH_NEWLINE, text_height: h_inc, last: 1'b1};
					end else begin
						lwidth_d  = '0;
						wpos_d    = pos_inc(pos1);
						push.res1 = '{out_pos: 16'(pos1), out_char: CH_NEWLINE,
							text_height: h_inc, last: 1'b1};
					end
				end else begin
					push.count = 2'd1;
					push.res0  = '{out_pos: 16'(wpos_q), out_char: char_s1,
						text_height: height_q, last: 1'b1};
				end
			end else begin
				// Loads, dropped characters and unused codes leave the state alone
				push.count = 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q   <= '0;
			lwidth_q <= '0;
			was_q    <= '0;
			spos_q   <= '0;
			sseen_q  <= 1'b0;
			height_q <= '0;
		end else begin
			wpos_q   <= wpos_d;
			lwidth_q <= lwidth_d;
			was_q    <= was_d;
			spos_q   <= spos_d;
			sseen_q  <= sseen_d;
			height_q <= height_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gww_out_fifo.sv =====
// Output queue: takes up to two results a cycle, hands out one per transfer.
// Depends on gww_pkg.
`default_nettype none

module gww_out_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire gww_pkg::push_t     push,
	output      logic               room,
	output      logic               result_valid,
	input  wire logic               result_ready,
	output      gww_pkg::out_item_t result
);
	import gww_pkg::*;

	out_item_t                mem_q [FIFO_DEPTH];
	logic [FIFO_IDX_BITS-1:0] head_q;
	logic [FIFO_IDX_BITS-1:0] tail_q;
	logic [FIFO_CNT_BITS-1:0] count_q;
	logic                     pop;
	logic [FIFO_IDX_BITS-1:0] tail_nx;

	assign pop          = result_valid && result_ready;
	assign result_valid = (count_q != '0);
	assign result       = mem_q[head_q];
	assign room         = (count_q <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
	assign tail_nx      = tail_q + FIFO_IDX_BITS'(1);

	// Entry storage
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[tail_q] <= push.res0;
		end
		if (push.count == 2'd2) begin
			mem_q[tail_nx] <= push.res1;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + FIFO_IDX_BITS'(push.count);
			if (pop) begin
				head_q <= head_q + FIFO_IDX_BITS'(1);
			end
			count_q <= count_q + FIFO_CNT_BITS'(push.count) - FIFO_CNT_BITS'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/greedy_word_wrap.sv =====
// Top level of the greedy word wrap block: APB registers, glyph table, wrap stage, queue.
// Depends on gww_pkg, gww_glyph_mem, gww_wrap_core and gww_out_fifo.
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+-----------------------------
//  item      | item_valid / item_ready       | in_item_t  (command, char)
//  result    | result_valid / result_ready   | out_item_t (pos, char, height)
//  config    | psel penable pwrite, pready=1 | paddr, pwdata, prdata
//
// One item per cycle while the output queue has room: the glyph table is read
// at acceptance, the item and the glyph read are registered, and the wrap stage
// then updates the line state and queues zero, one or two results.
// An item with two results hands them out in turn on the single result port;
// input stalls once the four-entry output queue cannot take two more.
// Reset clears the glyph table valid bits at once; no clearing pass is needed.
`default_nettype none

module greedy_word_wrap (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            item_valid,
	output      logic                            item_ready,
	input  wire gww_pkg::in_item_t               item,
	output      logic                            result_valid,
	input  wire logic                            result_ready,
	output      gww_pkg::out_item_t              result,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [gww_pkg::PADDR_BITS-1:0]  paddr,
	input  wire logic [31:0]                     pwdata,
	output      logic [31:0]                     prdata,
	output      logic                            pready
);
	import gww_pkg::*;

	logic [7:0]  line_height_q;
	logic [15:0] box_width_q;
	logic        cfg_wr;
	logic        accept;
	logic        load_wr;
	glyph_t      glyph_s1;
	glyph_t      glyph_wr;
	logic        fifo_room;
	push_t       push;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_height_q <= LINE_HEIGHT_RST;
			box_width_q   <= BOX_WIDTH_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_LINE_HEIGHT: line_height_q <= pwdata[7:0];
				REG_BOX_WIDTH:   box_width_q   <= pwdata[15:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_LINE_HEIGHT: prdata = {24'd0, line_height_q};
			REG_BOX_WIDTH:   prdata = {16'd0, box_width_q};
			default:         prdata = '0;
		endcase
	end

	// Glyph table: loads write at transfer, text reads at transfer
	assign accept   = item_valid && item_ready;
	assign load_wr  = accept && (item.command == CMD_LOAD) && in_table(item.char_code);
	assign glyph_wr = '{present: item.glyph_present,
		advance: item.glyph_present ? item.glyph_advance : 8'd0};

	gww_glyph_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.wr_en   (load_wr),
		.addr    (GLYPH_IDX_BITS'(item.char_code)),
		.wr_data (glyph_wr),
		.rd_data (glyph_s1)
	);

	gww_wrap_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_accept (accept),
		.item        (item),
		.glyph_s1    (glyph_s1),
		.fifo_room   (fifo_room),
		.line_height (line_height_q),
		.box_width   (box_width_q),
		.item_ready  (item_ready),
		.push        (push)
	);

	gww_out_fifo u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (fifo_room),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire
